>>> hdl/sct_pkg.sv
// package for the source code tokenizer: kinds, scan modes, packed words
package sct_pkg;

  localparam int PosBits = 16;
  localparam int OutBits = 16;
  localparam int LineBits = 16;
  localparam int KindBits = 6;
  localparam int PrefBits = 56;
  localparam int MaxRes = 3;

  typedef enum logic [3:0] {
    M_IDLE  = 4'd0,
    M_SLASH = 4'd1,
    M_LCOM  = 4'd2,
    M_BCOM  = 4'd3,
    M_BSTAR = 4'd4,
    M_IDENT = 4'd5,
    M_INT   = 4'd6,
    M_DOT   = 4'd7,
    M_FRAC  = 4'd8,
    M_STR   = 4'd9,
    M_HASH  = 4'd10,
    M_OP2   = 4'd11
  } scan_mode_e;

  localparam logic [KindBits-1:0] K_END      = 6'd0;
  localparam logic [KindBits-1:0] K_IDENT    = 6'd1;
  localparam logic [KindBits-1:0] K_NUMBER   = 6'd2;
  localparam logic [KindBits-1:0] K_STRING   = 6'd3;
  localparam logic [KindBits-1:0] K_INCLUDE  = 6'd4;
  localparam logic [KindBits-1:0] K_KW0      = 6'd5;
  localparam logic [KindBits-1:0] K_DOT      = 6'd30;
  localparam logic [KindBits-1:0] K_SLASH    = 6'd35;
  localparam logic [KindBits-1:0] K_ERR_DIR  = 6'd50;
  localparam logic [KindBits-1:0] K_ERR_STR  = 6'd51;
  localparam logic [KindBits-1:0] K_ERR_CHAR = 6'd52;
  localparam logic [KindBits-1:0] K_NONE     = 6'd0;

  // one emitted token
  typedef struct packed {
    logic [KindBits-1:0] kind;
    logic [OutBits-1:0]  start;
    logic [OutBits-1:0]  len;
    logic [LineBits-1:0] line;
  } tok_t;

  // keyword words, byte i in bits 8i+7:8i
  localparam logic [PrefBits-1:0] KwWord [17] = '{
    56'h0000_7373_616c_63, // class
    56'h0000_0065_736c_65, // else
    56'h0000_6573_6c61_66, // false
    56'h0000_0000_726f_66, // for
    56'h0000_0063_6e75_66, // func
    56'h0000_0000_0066_69, // if
    56'h0000_0000_746e_69, // int
    56'h0000_0000_7465_6c, // let
    56'h0000_006c_6c75_6e, // null
    56'h006e_7275_7465_72, // return
    56'h0000_7265_7075_73, // super
    56'h0067_6e69_7274_73, // string
    56'h0000_0073_6968_74, // this
    56'h0000_0065_7572_74, // true
    56'h0000_0000_7261_76, // var
    56'h0000_0064_696f_76, // void
    56'h0000_656c_6968_77  // while
  };
  localparam logic [PrefBits-1:0] IncWord = 56'h65_6475_6c63_6e69;

  function automatic logic [KindBits-1:0] kw_kind(input logic [PrefBits-1:0] w);
    logic [KindBits-1:0] k;
    k = K_IDENT;
    for (int i = 0; i < 17; i++) begin
      if (KwWord[i] == w) k = K_KW0 + KindBits'(i);
    end
    return k;
  endfunction

  function automatic logic [KindBits-1:0] single_op(input logic [7:0] c);
    logic [KindBits-1:0] k;
    case (c)
      8'h28: k = 6'd22;
      8'h29: k = 6'd23;
      8'h7b: k = 6'd24;
      8'h7d: k = 6'd25;
      8'h5b: k = 6'd26;
      8'h5d: k = 6'd27;
      8'h3b: k = 6'd28;
      8'h2c: k = 6'd29;
      8'h2e: k = 6'd30;
      8'h3a: k = 6'd31;
      8'h3f: k = 6'd32;
      8'h2d: k = 6'd33;
      8'h2b: k = 6'd34;
      8'h2a: k = 6'd36;
      8'h25: k = 6'd37;
      default: k = K_ERR_CHAR;
    endcase
    return k;
  endfunction

  function automatic logic [KindBits-1:0] op2_base(input logic [7:0] c);
    logic [KindBits-1:0] k;
    case (c)
      8'h21: k = 6'd38;
      8'h3d: k = 6'd40;
      8'h3c: k = 6'd42;
      8'h3e: k = 6'd44;
      8'h26: k = 6'd46;
      default: k = 6'd48;
    endcase
    return k;
  endfunction

  function automatic logic [OutBits-1:0] clamp_out(input logic [PosBits-1:0] v);
    logic [OutBits-1:0] r;
    if (PosBits <= OutBits) r = OutBits'(v);
    else if ((v >> OutBits) != '0) r = '1;
    else r = OutBits'(v);
    return r;
  endfunction

  function automatic logic [PosBits-1:0] sat_inc(input logic [PosBits-1:0] a,
                                                 input logic [1:0] b);
    logic [PosBits:0] s;
    s = {1'b0, a} + (PosBits+1)'(b);
    return s[PosBits] ? '1 : s[PosBits-1:0];
  endfunction

endpackage

>>> hdl/sct_scan.sv
// scanner step: state registers and per-byte token logic
module sct_scan (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [7:0]                ch_i,
  input  logic                      eos_i,
  output sct_pkg::tok_t             tok_o [sct_pkg::MaxRes],
  output logic [1:0]                cnt_o
);

  sct_pkg::scan_mode_e                 mode_q, mode_d;
  logic [sct_pkg::PosBits-1:0]         start_q, start_d;
  logic [sct_pkg::PosBits-1:0]         pos_q, pos_d;
  logic [sct_pkg::LineBits-1:0]        line_q, line_d;
  logic [sct_pkg::PosBits-1:0]         len_q, len_d;
  logic [sct_pkg::PrefBits-1:0]        pref_q, pref_d;
  logic [7:0]                          pend_q, pend_d;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= sct_pkg::M_IDLE;
      start_q <= '0;
      pos_q   <= '0;
      line_q  <= sct_pkg::LineBits'(1);
      len_q   <= '0;
      pref_q  <= '0;
      pend_q  <= '0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      start_q <= start_d;
      pos_q   <= pos_d;
      line_q  <= line_d;
      len_q   <= len_d;
      pref_q  <= pref_d;
      pend_q  <= pend_d;
    end
  end

  // next state and emitted tokens
  always_comb begin
    logic is_a, is_d, is_w, rescan, hash_ok;
    logic [7:0] c, want;
    logic [sct_pkg::KindBits-1:0] kd [3];
    logic [sct_pkg::PosBits-1:0] st [3];
    logic [sct_pkg::PosBits-1:0] ln [3];
    logic [1:0] n;
    logic [sct_pkg::PosBits-1:0] dotpos, hidx;
    c = ch_i;
    mode_d = mode_q; start_d = start_q; pos_d = pos_q; line_d = line_q;
    len_d = len_q; pref_d = pref_q; pend_d = pend_q;
    n = 2'd0; rescan = 1'b0;
    for (int i = 0; i < 3; i++) begin
      kd[i] = sct_pkg::K_NONE; st[i] = '0; ln[i] = '0;
    end
    is_a = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
    is_d = c >= 8'h30 && c <= 8'h39;
    is_w = is_a || is_d || c == 8'h5f;
    want = (pend_q == 8'h26 || pend_q == 8'h7c) ? pend_q : 8'h3d;
    hash_ok = len_q == sct_pkg::PosBits'(8) && pref_q == sct_pkg::IncWord;
    begin
      logic [sct_pkg::PosBits:0] s;
      s = {1'b0, start_q} + {1'b0, len_q};
      dotpos = s[sct_pkg::PosBits] ? '1 : s[sct_pkg::PosBits-1:0];
    end
    hidx = len_q - sct_pkg::PosBits'(1);

    if (eos_i || c == 8'h00) begin
      // flush pending token, then end token and restart
      case (mode_q)
        sct_pkg::M_SLASH: begin
          kd[n] = sct_pkg::K_SLASH; st[n] = start_q; ln[n] = sct_pkg::PosBits'(1);
          n = n + 2'd1;
        end
        sct_pkg::M_IDENT: begin
          kd[n] = sct_pkg::kw_kind(pref_q); st[n] = start_q; ln[n] = len_q;
          n = n + 2'd1;
        end
        sct_pkg::M_HASH: begin
          kd[n] = hash_ok ? sct_pkg::K_INCLUDE : sct_pkg::K_ERR_DIR;
          st[n] = start_q; ln[n] = len_q; n = n + 2'd1;
        end
        sct_pkg::M_INT, sct_pkg::M_FRAC: begin
          kd[n] = sct_pkg::K_NUMBER; st[n] = start_q; ln[n] = len_q;
          n = n + 2'd1;
        end
        sct_pkg::M_DOT: begin
          kd[0] = sct_pkg::K_NUMBER; st[0] = start_q; ln[0] = len_q;
          kd[1] = sct_pkg::K_DOT; st[1] = dotpos; ln[1] = sct_pkg::PosBits'(1);
          n = 2'd2;
        end
        sct_pkg::M_STR: begin
          kd[n] = sct_pkg::K_ERR_STR; st[n] = start_q; ln[n] = len_q;
          n = n + 2'd1;
        end
        sct_pkg::M_OP2: begin
          kd[n] = sct_pkg::op2_base(pend_q); st[n] = start_q;
          ln[n] = sct_pkg::PosBits'(1); n = n + 2'd1;
        end
        default: ;
      endcase
      kd[n] = sct_pkg::K_END; st[n] = pos_q; ln[n] = '0;
      n = n + 2'd1;
      mode_d = sct_pkg::M_IDLE; start_d = '0; pos_d = '0;
      line_d = sct_pkg::LineBits'(1); len_d = '0; pref_d = '0; pend_d = '0;
    end else begin
      // continue the open token
      case (mode_q)
        sct_pkg::M_SLASH: begin
          if (c == 8'h2f) mode_d = sct_pkg::M_LCOM;
          else if (c == 8'h2a) mode_d = sct_pkg::M_BCOM;
          else begin
            kd[0] = sct_pkg::K_SLASH; st[0] = start_q; ln[0] = sct_pkg::PosBits'(1);
            n = 2'd1; rescan = 1'b1;
          end
        end
        sct_pkg::M_LCOM: begin
          if (c == 8'h0a) begin
            if (line_q != '1) line_d = line_q + 1'b1;
            mode_d = sct_pkg::M_IDLE;
          end
        end
        sct_pkg::M_BCOM, sct_pkg::M_BSTAR: begin
          if (mode_q == sct_pkg::M_BSTAR && c == 8'h2f) mode_d = sct_pkg::M_IDLE;
          else begin
            if (c == 8'h0a && line_q != '1) line_d = line_q + 1'b1;
            mode_d = (c == 8'h2a) ? sct_pkg::M_BSTAR : sct_pkg::M_BCOM;
          end
        end
        sct_pkg::M_IDENT: begin
          if (is_w) begin
            for (int i = 0; i < 7; i++) begin
              if (len_q == sct_pkg::PosBits'(i)) pref_d[8*i +: 8] = pref_q[8*i +: 8] | c;
            end
            len_d = sct_pkg::sat_inc(len_q, 2'd1);
          end else begin
            kd[0] = sct_pkg::kw_kind(pref_q); st[0] = start_q; ln[0] = len_q;
            n = 2'd1; rescan = 1'b1;
          end
        end
        sct_pkg::M_HASH: begin
          if (is_a) begin
            for (int i = 0; i < 7; i++) begin
              if (hidx == sct_pkg::PosBits'(i)) pref_d[8*i +: 8] = pref_q[8*i +: 8] | c;
            end
            len_d = sct_pkg::sat_inc(len_q, 2'd1);
          end else begin
            kd[0] = hash_ok ? sct_pkg::K_INCLUDE : sct_pkg::K_ERR_DIR;
            st[0] = start_q; ln[0] = len_q; n = 2'd1; rescan = 1'b1;
          end
        end
        sct_pkg::M_INT: begin
          if (is_d) len_d = sct_pkg::sat_inc(len_q, 2'd1);
          else if (c == 8'h2e) mode_d = sct_pkg::M_DOT;
          else begin
            kd[0] = sct_pkg::K_NUMBER; st[0] = start_q; ln[0] = len_q;
            n = 2'd1; rescan = 1'b1;
          end
        end
        sct_pkg::M_DOT: begin
          if (is_d) begin
            len_d = sct_pkg::sat_inc(len_q, 2'd2);
            mode_d = sct_pkg::M_FRAC;
          end else begin
            kd[0] = sct_pkg::K_NUMBER; st[0] = start_q; ln[0] = len_q;
            kd[1] = sct_pkg::K_DOT; st[1] = dotpos; ln[1] = sct_pkg::PosBits'(1);
            n = 2'd2; rescan = 1'b1;
          end
        end
        sct_pkg::M_FRAC: begin
          if (is_d) len_d = sct_pkg::sat_inc(len_q, 2'd1);
          else begin
            kd[0] = sct_pkg::K_NUMBER; st[0] = start_q; ln[0] = len_q;
            n = 2'd1; rescan = 1'b1;
          end
        end
        sct_pkg::M_STR: begin
          len_d = sct_pkg::sat_inc(len_q, 2'd1);
          if (c == 8'h22) begin
            kd[0] = sct_pkg::K_STRING; st[0] = start_q; ln[0] = len_d;
            n = 2'd1; mode_d = sct_pkg::M_IDLE;
          end else if (c == 8'h0a && line_q != '1) line_d = line_q + 1'b1;
        end
        sct_pkg::M_OP2: begin
          if (c == want) begin
            kd[0] = sct_pkg::op2_base(pend_q) + 6'd1; st[0] = start_q;
            ln[0] = sct_pkg::PosBits'(2); n = 2'd1; mode_d = sct_pkg::M_IDLE;
          end else begin
            kd[0] = sct_pkg::op2_base(pend_q); st[0] = start_q;
            ln[0] = sct_pkg::PosBits'(1); n = 2'd1; rescan = 1'b1;
          end
        end
        default: rescan = 1'b1;
      endcase

      // scan the byte from idle
      if (rescan) begin
        mode_d = sct_pkg::M_IDLE;
        if (c == 8'h20 || c == 8'h09 || c == 8'h0d) begin
        end else if (c == 8'h0a) begin
          if (line_q != '1) line_d = line_q + 1'b1;
        end else if (c == 8'h2f || c == 8'h23 || is_w || c == 8'h22 ||
                     c == 8'h21 || c == 8'h3d || c == 8'h3c || c == 8'h3e ||
                     c == 8'h26 || c == 8'h7c) begin
          start_d = pos_q; len_d = sct_pkg::PosBits'(1); pref_d = '0;
          if (c == 8'h2f) mode_d = sct_pkg::M_SLASH;
          else if (c == 8'h23) mode_d = sct_pkg::M_HASH;
          else if (is_d) mode_d = sct_pkg::M_INT;
          else if (is_w) begin
            mode_d = sct_pkg::M_IDENT;
            pref_d[7:0] = c;
          end else if (c == 8'h22) mode_d = sct_pkg::M_STR;
          else begin
            mode_d = sct_pkg::M_OP2;
            pend_d = c;
          end
        end else begin
          kd[n] = sct_pkg::single_op(c); st[n] = pos_q; ln[n] = sct_pkg::PosBits'(1);
          n = n + 2'd1;
        end
      end
      pos_d = sct_pkg::sat_inc(pos_q, 2'd1);
    end

    // tokens carry the line count from before this byte
    for (int i = 0; i < 3; i++) begin
      tok_o[i].kind  = kd[i];
      tok_o[i].start = sct_pkg::clamp_out(st[i]);
      tok_o[i].len   = sct_pkg::clamp_out(ln[i]);
      tok_o[i].line  = line_q;
    end
    cnt_o = n;
  end

  // line counter never goes to zero
  a_line_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q != '0) else $error("line count zero");
  // end of source always restarts scanning
  a_eos_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && eos_i |=> mode_q == sct_pkg::M_IDLE && pos_q == '0)
    else $error("no restart after end");
  // end of source always gives a token
  a_eos_tok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eos_i |-> cnt_o != 2'd0) else $error("end without token");

endmodule

>>> hdl/source_code_tokenizer_top.sv
// top level of the source code tokenizer: byte stream in, token stream out
//
// channel  dir  fields (tdata low bit up)
// s_axis   in   tdata: ch[7:0]; tuser: end_of_source
// m_axis   out  tdata: token_kind[5:0], start_pos, token_len, line_no, pad; tlast: last
//
// one byte is scanned per cycle; its up to three tokens go into a six-entry
// token queue and leave one per cycle. a byte is taken when the queue has room
// for three more tokens, so a byte giving one token sustains one byte a cycle.
// reset returns the scanner to idle at offset zero, line one, queue empty.
// a stall on m_axis holds the queue and backs up s_axis_tready.
module source_code_tokenizer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // ch
  input  logic        s_axis_tuser,   // end_of_source
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // token_kind, start_pos, token_len, line_no, pad
  output logic        m_axis_tlast    // last
);

  localparam int QDepth = 6;

  sct_pkg::tok_t tok [sct_pkg::MaxRes];
  logic [1:0]    cnt;
  logic          step;

  typedef struct packed {
    sct_pkg::tok_t tok;
    logic          last;
  } qent_t;

  qent_t       q_q [QDepth];
  logic [2:0]  wp_q, rp_q;
  logic [3:0]  fill_q;

  assign s_axis_tready = fill_q <= 4'(QDepth - 3);
  assign step = s_axis_tvalid && s_axis_tready;

  sct_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .ch_i   (s_axis_tdata),
    .eos_i  (s_axis_tuser),
    .tok_o  (tok),
    .cnt_o  (cnt)
  );

  logic pop;
  logic [1:0] push_n;
  assign pop = m_axis_tvalid && m_axis_tready;
  assign push_n = step ? cnt : 2'd0;

  function automatic logic [2:0] wrap(input logic [2:0] a, input logic [1:0] b);
    logic [3:0] s;
    s = {1'b0, a} + {2'b0, b};
    return (s >= 4'(QDepth)) ? 3'(s - 4'(QDepth)) : s[2:0];
  endfunction

  // token queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      fill_q <= '0;
    end else begin
      wp_q <= wrap(wp_q, push_n);
      rp_q <= wrap(rp_q, {1'b0, pop});
      fill_q <= fill_q + {2'b0, push_n} - {3'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < sct_pkg::MaxRes; i++) begin
      if (2'(i) < push_n) begin
        q_q[wrap(wp_q, 2'(i))] <= '{tok: tok[i], last: 2'(i + 1) == push_n};
      end
    end
  end

  assign m_axis_tvalid = fill_q != '0;
  assign m_axis_tdata = {2'b0, q_q[rp_q].tok.line, q_q[rp_q].tok.len,
                         q_q[rp_q].tok.start, q_q[rp_q].tok.kind};
  assign m_axis_tlast = q_q[rp_q].last;

  // queue never overfills
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= 4'(QDepth)) else $error("queue overflow");
  // a held beat stays
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("beat lost");
  // pointers agree with fill
  a_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q == '0 |-> wp_q == rp_q) else $error("pointer mismatch");

endmodule

>>> dv/tb_top.sv
// testbench for the source code tokenizer: byte stream stimulus, token checks
module tb_top;

  // token fields as they travel on the output stream
  typedef struct {
    logic [5:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
    logic [15:0] line;
    logic        lst;
  } token_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tlast;

  source_code_tokenizer_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  token_t     token_q[$];
  int         n_mismatch = 0;
  int         cycle_cnt = 0;
  int         hold_off = 0;
  bit         idle_rx = 1'b1;
  bit         done = 1'b0;

  // scanner state mirror
  sct_pkg::scan_mode_e mode;
  logic [15:0] tok_start, pos, line, tok_len;
  logic [55:0] prefix;
  logic [7:0]  pend;
  int          n_out;
  token_t      step_toks[$];

  // keyword words, byte i in bits 8i+7:8i
  function automatic logic [55:0] word_of(string s);
    logic [55:0] w;
    w = '0;
    for (int i = 0; i < s.len() && i < 7; i++) w[8*i +: 8] = s[i];
    return w;
  endfunction

  function automatic logic [15:0] sat16(logic [15:0] a, int b);
    int s;
    s = a + b;
    return (s > 65535) ? 16'hffff : 16'(s);
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [5:0] op_kind(logic [7:0] c);
    case (c)
      "(": return 6'd22;  ")": return 6'd23;  "{": return 6'd24;
      "}": return 6'd25;  "[": return 6'd26;  "]": return 6'd27;
      ";": return 6'd28;  ",": return 6'd29;  ".": return sct_pkg::K_DOT;
      ":": return 6'd31;  "?": return 6'd32;  "-": return 6'd33;
      "+": return 6'd34;  "*": return 6'd36;  "%": return 6'd37;
      default: return sct_pkg::K_ERR_CHAR;
    endcase
  endfunction

  function automatic logic [5:0] pend_kind(logic [7:0] c);
    case (c)
      "!": return 6'd38;  "=": return 6'd40;  "<": return 6'd42;
      ">": return 6'd44;  "&": return 6'd46;  default: return 6'd48;
    endcase
  endfunction

  function automatic void put_token(logic [5:0] k, logic [15:0] s, logic [15:0] l);
    token_t t;
    if (n_out >= 3) return;
    t.kind = k; t.start = s; t.len = l; t.line = line; t.lst = 1'b0;
    step_toks.push_back(t);
    n_out++;
  endfunction

  function automatic void bump_line();
    if (line != 16'hffff) line++;
  endfunction

  function automatic void open_token(sct_pkg::scan_mode_e m);
    mode = m; tok_start = pos; tok_len = 1; prefix = '0;
  endfunction

  function automatic void add_prefix(int idx, logic [7:0] c);
    if (idx < 7) prefix[8*idx +: 8] = c;
  endfunction

  function automatic void close_word();
    string kw[17];
    logic [5:0] k;
    kw = '{"class", "else", "false", "for", "func", "if", "int", "let", "null",
           "return", "super", "string", "this", "true", "var", "void", "while"};
    k = sct_pkg::K_IDENT;
    for (int i = 0; i < 17; i++) begin
      if (word_of(kw[i]) == prefix) k = sct_pkg::K_KW0 + 6'(i);
    end
    put_token(k, tok_start, tok_len);
  endfunction

  function automatic void close_directive();
    put_token((tok_len == 8 && prefix == word_of("include")) ?
              sct_pkg::K_INCLUDE : sct_pkg::K_ERR_DIR, tok_start, tok_len);
  endfunction

  function automatic void scan_fresh(logic [7:0] c);
    mode = sct_pkg::M_IDLE;
    if (c == " " || c == 8'h09 || c == 8'h0d) return;
    if (c == 8'h0a) begin bump_line(); return; end
    if (c == "/") begin open_token(sct_pkg::M_SLASH); return; end
    if (c == "#") begin open_token(sct_pkg::M_HASH); return; end
    if (is_alpha(c) || c == "_") begin
      open_token(sct_pkg::M_IDENT); add_prefix(0, c); return;
    end
    if (is_digit(c)) begin open_token(sct_pkg::M_INT); return; end
    if (c == 8'h22) begin open_token(sct_pkg::M_STR); return; end
    if (c == "!" || c == "=" || c == "<" || c == ">" || c == "&" || c == "|") begin
      open_token(sct_pkg::M_OP2); pend = c; return;
    end
    put_token(op_kind(c), pos, 1);
  endfunction

  function automatic void scan_byte(logic [7:0] c);
    logic [7:0] want;
    case (mode)
      sct_pkg::M_SLASH: begin
        if (c == "/") begin mode = sct_pkg::M_LCOM; return; end
        if (c == "*") begin mode = sct_pkg::M_BCOM; return; end
        put_token(sct_pkg::K_SLASH, tok_start, 1);
      end
      sct_pkg::M_LCOM: begin
        if (c == 8'h0a) begin bump_line(); mode = sct_pkg::M_IDLE; end
        return;
      end
      sct_pkg::M_BCOM, sct_pkg::M_BSTAR: begin
        if (mode == sct_pkg::M_BSTAR && c == "/") begin mode = sct_pkg::M_IDLE; return; end
        if (c == 8'h0a) bump_line();
        mode = (c == "*") ? sct_pkg::M_BSTAR : sct_pkg::M_BCOM;
        return;
      end
      sct_pkg::M_IDENT: begin
        if (is_alpha(c) || is_digit(c) || c == "_") begin
          add_prefix(tok_len, c); tok_len = sat16(tok_len, 1); return;
        end
        close_word();
      end
      sct_pkg::M_HASH: begin
        if (is_alpha(c)) begin
          add_prefix(int'(tok_len) - 1, c); tok_len = sat16(tok_len, 1); return;
        end
        close_directive();
      end
      sct_pkg::M_INT: begin
        if (is_digit(c)) begin tok_len = sat16(tok_len, 1); return; end
        if (c == ".") begin mode = sct_pkg::M_DOT; return; end
        put_token(sct_pkg::K_NUMBER, tok_start, tok_len);
      end
      sct_pkg::M_DOT: begin
        if (is_digit(c)) begin
          tok_len = sat16(tok_len, 2); mode = sct_pkg::M_FRAC; return;
        end
        put_token(sct_pkg::K_NUMBER, tok_start, tok_len);
        put_token(sct_pkg::K_DOT, sat16(tok_start, tok_len), 1);
      end
      sct_pkg::M_FRAC: begin
        if (is_digit(c)) begin tok_len = sat16(tok_len, 1); return; end
        put_token(sct_pkg::K_NUMBER, tok_start, tok_len);
      end
      sct_pkg::M_STR: begin
        tok_len = sat16(tok_len, 1);
        if (c == 8'h22) begin
          put_token(sct_pkg::K_STRING, tok_start, tok_len); mode = sct_pkg::M_IDLE;
        end else if (c == 8'h0a) bump_line();
        return;
      end
      sct_pkg::M_OP2: begin
        want = (pend == "&" || pend == "|") ? pend : "=";
        if (c == want) begin
          put_token(pend_kind(pend) + 6'd1, tok_start, 2); mode = sct_pkg::M_IDLE; return;
        end
        put_token(pend_kind(pend), tok_start, 1);
      end
      default: ;
    endcase
    scan_fresh(c);
  endfunction

  function automatic void clear_scanner();
    mode = sct_pkg::M_IDLE; tok_start = 0; pos = 0; line = 1; tok_len = 0;
    prefix = '0; pend = 0;
  endfunction

  // predict the tokens of one byte and queue them
  function automatic void predict_tokens(logic [7:0] c, logic eos);
    n_out = 0;
    step_toks.delete();
    if (eos || c == 0) begin
      case (mode)
        sct_pkg::M_SLASH: put_token(sct_pkg::K_SLASH, tok_start, 1);
        sct_pkg::M_IDENT: close_word();
        sct_pkg::M_HASH: close_directive();
        sct_pkg::M_INT, sct_pkg::M_FRAC: put_token(sct_pkg::K_NUMBER, tok_start, tok_len);
        sct_pkg::M_DOT: begin
          put_token(sct_pkg::K_NUMBER, tok_start, tok_len);
          put_token(sct_pkg::K_DOT, sat16(tok_start, tok_len), 1);
        end
        sct_pkg::M_STR: put_token(sct_pkg::K_ERR_STR, tok_start, tok_len);
        sct_pkg::M_OP2: put_token(pend_kind(pend), tok_start, 1);
        default: ;
      endcase
      put_token(sct_pkg::K_END, pos, 0);
      clear_scanner();
    end else begin
      scan_byte(c);
      pos = sat16(pos, 1);
    end
    if (n_out > 0) step_toks[n_out-1].lst = 1'b1;
    foreach (step_toks[i]) token_q.push_back(step_toks[i]);
  endfunction

  // send one byte, with a random gap before it; valid drops during a gap and stays up otherwise
  task automatic send_byte(logic [7:0] c, logic eos = 1'b0);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata <= c;
    s_axis_tuser <= eos;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_tokens(c, eos);
    @(negedge clk_i);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // receiver readiness, with random stalls and a forced long hold-off
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_rx) begin
      m_axis_tready <= ($urandom_range(0, 9) == 0) ? 1'b0 : 1'b1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // token checker
  always @(posedge clk_i) begin
    token_t exp_t;
    cycle_cnt <= cycle_cnt + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (token_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected token %h", m_axis_tdata);
      end else begin
        exp_t = token_q.pop_front();
        if (m_axis_tdata[5:0] !== exp_t.kind || m_axis_tdata[21:6] !== exp_t.start ||
            m_axis_tdata[37:22] !== exp_t.len || m_axis_tdata[53:38] !== exp_t.line ||
            m_axis_tlast !== exp_t.lst) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display({"token mismatch: exp kind %0d start %0d len %0d line %0d",
                      " last %0d, got %h last %0d"},
                     exp_t.kind, exp_t.start, exp_t.len, exp_t.line, exp_t.lst,
                     m_axis_tdata, m_axis_tlast);
        end
      end
    end
  end

  // timeout
  always @(posedge clk_i) begin
    if (cycle_cnt > 400000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic test_keywords();
    send_text("class else false for func if int let null return super string ");
    send_text("this true var void while iff intx\n");
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_numbers_and_ops();
    send_text("1.( 12.5 7. 3x()[]{};,:?-+*% != ! == = <= < >= > && & || | ");
    send_text("#include #incl \"s\n\" @");
    send_byte(8'h80); send_byte(8'hff); send_byte(8'h01);
    send_byte(8'h00);
  endtask

  task automatic test_comments_and_ends();
    send_text("a // l\n/* b * x\n **/ b / c");
    send_byte(8'h00, 1'b1);
    send_text("\"o"); send_byte(8'h55, 1'b1);
    send_text("/*"); send_byte(8'h00, 1'b1);
    send_text("<"); send_byte(8'h00, 1'b1);
    send_text("1."); send_byte(8'h00, 1'b1);
    send_text("#in"); send_byte(8'h00, 1'b1);
  endtask

  // long receiver stall while bytes keep coming
  task automatic test_backpressure();
    hold_off = 200;
    for (int i = 0; i < 8; i++) send_text("( ");
    send_byte(8'h00, 1'b1);
  endtask

  // a string spanning several lines
  task automatic test_long_token();
    send_byte(8'h22);
    for (int i = 0; i < 5; i++) send_byte(8'h0a);
    send_text("\"x");
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_random();
    string frags[16];
    frags = '{"int ", "while", "x_1", "3.14", "7.", "\"ab c\"", "// c\n", "/* * */",
              "#include", "#foo", "&&", "||", "<=", "!", "\n", " "};
    for (int i = 0; i < 15; i++) begin
      case ($urandom_range(0, 9))
        0: send_byte(8'($urandom_range(0, 255)));
        1: send_byte(8'($urandom_range(32, 126)));
        2: send_byte(8'h00, 1'b1);
        3: send_byte(8'($urandom_range(0, 255)), 1'b1);
        default: send_text(frags[$urandom_range(0, 15)]);
      endcase
      if (i % 5 == 4) idle_rx = ~idle_rx;
    end
    send_byte(8'h00, 1'b1);
  endtask

  initial begin
    clear_scanner();
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    test_keywords();
    test_numbers_and_ops();
    test_comments_and_ends();
    test_backpressure();
    test_long_token();
    test_random();
    s_axis_tvalid <= 1'b0;
    while (token_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (n_mismatch == 0 && token_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
